// ----- sv/frm_pkg.sv -----
// ----------------------------------------------------------------------------
// frm_pkg
// Shared constants, widths and types of the frame rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

   // history ring
   localparam int HISTORY_DEPTH = 64;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int STEPS         = HISTORY_DEPTH - 1;

   // field widths
   localparam int TIME_W = 32;
   localparam int CNT_W  = 16;
   localparam int RATE_W = 16;
   localparam int WIN_W  = 16;
   localparam int MARK_W = 8;
   localparam int CFG_W  = 12;
   localparam int POS_W  = 13;

   // rate arithmetic: rate = (count*2000 + elapsed) / (2*elapsed)
   localparam int FRAME_SCALE = 2000;
   localparam int SCALE_W     = 11;
   localparam int SCALED_W    = CNT_W + SCALE_W;
   localparam int DIV_W       = 33;
   localparam int DIV_CW      = $clog2(DIV_W);

   // x stepping: width / STEPS by reciprocal, exact for 12-bit widths
   localparam int ERR_W    = $clog2(2 * STEPS);
   localparam int X_SHIFT  = CFG_W + $clog2(STEPS);
   localparam int X_PROD_W = X_SHIFT + CFG_W;
   localparam int X_RECIP  = (2 ** X_SHIFT + STEPS - 1) / STEPS;

   // y scaling: min(v,90)*height/90 by reciprocal, exact below 2^19
   localparam int FULL_SCALE = 90;
   localparam int CLAMP_W    = 7;
   localparam int YP_W       = CLAMP_W + CFG_W;
   localparam int Y_SHIFT    = YP_W + CLAMP_W;
   localparam int Y_RECIP    = (2 ** Y_SHIFT + FULL_SCALE - 1) / FULL_SCALE;
   localparam int Y_RECIP_W  = $clog2(Y_RECIP + 1);
   localparam int YM_W       = YP_W + Y_RECIP_W;

   typedef struct packed {
      logic [MARK_W-1:0] low_rate_mark;
      logic [CFG_W-1:0]  left;
      logic [CFG_W-1:0]  top;
      logic [CFG_W-1:0]  width;
      logic [CFG_W-1:0]  height;
   } frm_cfg_type;

   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
   } frm_rd_type;

   typedef struct packed {
      logic               en;
      logic [HIST_AW-1:0] addr;
      logic [RATE_W-1:0]  data;
   } frm_wr_type;

   typedef struct packed {
      logic              valid;
      logic [RATE_W-1:0] rate;
      logic [POS_W-1:0]  start_x;
      logic [POS_W-1:0]  start_y;
      logic [POS_W-1:0]  end_x;
      logic [POS_W-1:0]  end_y;
      logic              slow;
      logic              last;
   } frm_seg_type;

endpackage

`default_nettype wire

// ----- sv/frm_req_if.sv -----
// ----------------------------------------------------------------------------
// frm_req_if
// Request channel: frame event or plot request.
// ----------------------------------------------------------------------------
`default_nettype none

interface frm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [frm_pkg::TIME_W-1:0]  time_ms;

   modport source (output valid, output command, output time_ms, input ready);
   modport sink   (input valid, input command, input time_ms, output ready);
endinterface

`default_nettype wire

// ----- sv/frm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// frm_rsp_if
// Result channel: rate samples and plot segments.
// ----------------------------------------------------------------------------
`default_nettype none

interface frm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [frm_pkg::RATE_W-1:0]  rate;
   logic [frm_pkg::POS_W-1:0]   start_x;
   logic [frm_pkg::POS_W-1:0]   start_y;
   logic [frm_pkg::POS_W-1:0]   end_x;
   logic [frm_pkg::POS_W-1:0]   end_y;
   logic                        slow;
   logic                        last;

   modport source (output valid, output kind, output rate, output start_x, output start_y,
                   output end_x, output end_y, output slow, output last, input ready);
   modport sink   (input valid, input kind, input rate, input start_x, input start_y,
                   input end_x, input end_y, input slow, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/frm_div.sv -----
// ----------------------------------------------------------------------------
// frm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [frm_pkg::DIV_W-1:0]  num,
   input  logic [frm_pkg::DIV_W-1:0]  den,
   output logic                       done,
   output logic [frm_pkg::DIV_W-1:0]  quo
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [frm_pkg::DIV_CW-1:0]  cnt_ff;
   logic [frm_pkg::DIV_W-1:0]   rem_ff;
   logic [frm_pkg::DIV_W-1:0]   quo_ff;
   logic [frm_pkg::DIV_W-1:0]   den_ff;
   logic [frm_pkg::DIV_W:0]     rem_sh;
   logic                        ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[frm_pkg::DIV_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= frm_pkg::DIV_CW'(frm_pkg::DIV_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // numerator bits shift out of the top of quo_ff as quotient bits enter
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? frm_pkg::DIV_W'(rem_sh - {1'b0, den_ff}) : rem_sh[frm_pkg::DIV_W-1:0];
         quo_ff <= {quo_ff[frm_pkg::DIV_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

// ----- sv/frm_hist_ram.sv -----
// ----------------------------------------------------------------------------
// frm_hist_ram
// Rate history memory, one write and one registered read port.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_hist_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  frm_pkg::frm_rd_type         rd,
   input  frm_pkg::frm_wr_type         wr,
   output logic [frm_pkg::RATE_W-1:0]  rd_data
);

   logic [frm_pkg::RATE_W-1:0]         mem [frm_pkg::HISTORY_DEPTH];
   logic [frm_pkg::HISTORY_DEPTH-1:0]  valid_ff;
   logic [frm_pkg::RATE_W-1:0]         data_ff;
   logic                               hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         data_ff <= mem[rd.addr];
         hit_ff  <= valid_ff[rd.addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

`default_nettype wire

// ----- sv/frm_plot.sv -----
// ----------------------------------------------------------------------------
// frm_plot
// Plot engine: walks the history ring oldest first, one read per cycle
// on adv, scales entries to y positions, pairs neighbors into segments.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_plot (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [frm_pkg::HIST_AW-1:0]  wp,
   input  frm_pkg::frm_cfg_type         cfg,
   input  logic                         adv,
   output frm_pkg::frm_rd_type          rd,
   input  logic [frm_pkg::RATE_W-1:0]   rd_data,
   output frm_pkg::frm_seg_type         seg,
   output logic                         busy
);

   typedef enum logic [4:0] {
      P_IDLE  = 5'b00001,
      P_QUO   = 5'b00010,
      P_REM   = 5'b00100,
      P_ISSUE = 5'b01000,
      P_DRAIN = 5'b10000
   } plot_state_type;

   plot_state_type                 state_ff, state_in;
   logic [frm_pkg::CFG_W-1:0]      q_ff;
   logic [frm_pkg::ERR_W-1:0]      r_ff;
   logic [frm_pkg::HIST_AW-1:0]    addr_ff;
   logic [frm_pkg::HIST_AW-1:0]    j_ff;

   logic                           v1_ff, first1_ff, last1_ff;
   logic                           v2_ff, first2_ff, last2_ff;
   logic                           v3_ff, first3_ff, last3_ff;
   logic [frm_pkg::CLAMP_W-1:0]    c2_ff, c3_ff;
   logic [frm_pkg::YP_W-1:0]       p2_ff;
   logic [frm_pkg::POS_W-1:0]      y3_ff;

   logic [frm_pkg::POS_W-1:0]      cur_x_ff;
   logic [frm_pkg::ERR_W-1:0]      err_ff;
   logic [frm_pkg::POS_W-1:0]      prev_y_ff;

   logic                           issuing;
   logic                           issue;
   logic                           j_end;
   logic [frm_pkg::X_PROD_W-1:0]   xprod;
   logic [frm_pkg::CFG_W-1:0]      qr_prod;
   logic [frm_pkg::CLAMP_W-1:0]    c1;
   logic [frm_pkg::YP_W-1:0]       p1;
   logic [frm_pkg::YM_W-1:0]       yprod;
   logic [frm_pkg::POS_W-1:0]      bottom;
   logic [frm_pkg::POS_W-1:0]      y2;
   logic [frm_pkg::ERR_W-1:0]      err_sum;
   logic [frm_pkg::ERR_W-1:0]      err_next;
   logic                           wrap;
   logic [frm_pkg::POS_W-1:0]      next_x;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         P_IDLE:  if (start) state_in = P_QUO;
         P_QUO:   state_in = P_REM;
         P_REM:   state_in = P_ISSUE;
         P_ISSUE: if (adv && j_end) state_in = P_DRAIN;
         P_DRAIN: if (!v1_ff && !v2_ff && !v3_ff) state_in = P_IDLE;
         default: state_in = P_IDLE;
      endcase
   end

   always_comb begin
      issuing = (state_ff == P_ISSUE);
      issue   = issuing && adv;
      j_end   = (j_ff == frm_pkg::HIST_AW'(frm_pkg::STEPS));

      // x step quotient and remainder
      xprod   = frm_pkg::X_PROD_W'(cfg.width) * frm_pkg::X_PROD_W'(frm_pkg::X_RECIP);
      qr_prod = frm_pkg::CFG_W'(q_ff * frm_pkg::CFG_W'(frm_pkg::STEPS));

      // stage 1: clamp and scale by height
      c1 = (rd_data > frm_pkg::RATE_W'(frm_pkg::FULL_SCALE)) ?
           frm_pkg::CLAMP_W'(frm_pkg::FULL_SCALE) : rd_data[frm_pkg::CLAMP_W-1:0];
      p1 = frm_pkg::YP_W'(c1) * frm_pkg::YP_W'(cfg.height);

      // stage 2: divide by full scale, measure down from the bottom edge
      yprod  = frm_pkg::YM_W'(p2_ff) * frm_pkg::YM_W'(frm_pkg::Y_RECIP);
      bottom = frm_pkg::POS_W'(cfg.top) + frm_pkg::POS_W'(cfg.height);
      y2     = bottom - frm_pkg::POS_W'(yprod[frm_pkg::Y_SHIFT +: frm_pkg::CFG_W]);

      // output stage: x advance with remainder accumulation
      err_sum  = err_ff + r_ff;
      wrap     = (err_sum >= frm_pkg::ERR_W'(frm_pkg::STEPS));
      err_next = wrap ? err_sum - frm_pkg::ERR_W'(frm_pkg::STEPS) : err_sum;
      next_x   = cur_x_ff + frm_pkg::POS_W'(q_ff) + frm_pkg::POS_W'(wrap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (adv) begin
            v1_ff <= issuing;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == P_IDLE && start) begin
         addr_ff  <= wp;
         j_ff     <= '0;
         cur_x_ff <= frm_pkg::POS_W'(cfg.left);
         err_ff   <= '0;
      end
      if (state_ff == P_QUO) begin
         q_ff <= xprod[frm_pkg::X_SHIFT +: frm_pkg::CFG_W];
      end
      if (state_ff == P_REM) begin
         r_ff <= frm_pkg::ERR_W'(cfg.width - qr_prod);
      end
      if (issue) begin
         j_ff    <= j_ff + 1'b1;
         addr_ff <= (addr_ff == frm_pkg::HIST_AW'(frm_pkg::STEPS)) ? '0 : addr_ff + 1'b1;
      end
      if (adv) begin
         first1_ff <= (j_ff == '0);
         last1_ff  <= j_end;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         c2_ff     <= c1;
         p2_ff     <= p1;
         first3_ff <= first2_ff;
         last3_ff  <= last2_ff;
         c3_ff     <= c2_ff;
         y3_ff     <= y2;
      end
      if (adv && v3_ff) begin
         prev_y_ff <= y3_ff;
         if (!first3_ff) begin
            cur_x_ff <= next_x;
            err_ff   <= err_next;
         end
      end
   end

   always_comb begin
      rd.en   = issue;
      rd.addr = addr_ff;

      seg.valid   = v3_ff && !first3_ff;
      seg.rate    = frm_pkg::RATE_W'(c3_ff);
      seg.start_x = cur_x_ff;
      seg.start_y = prev_y_ff;
      seg.end_x   = next_x;
      seg.end_y   = y3_ff;
      seg.slow    = frm_pkg::MARK_W'(c3_ff) < cfg.low_rate_mark;
      seg.last    = last3_ff;

      busy = (state_ff != P_IDLE);
   end

endmodule

`default_nettype wire

// ----- sv/frame_rate_meter_with_history_plot.sv -----
// ----------------------------------------------------------------------------
// frame_rate_meter_with_history_plot
// Frame rate meter with a 64-entry rate history and a line-graph plotter.
//
//   channel  dir  handshake               payload
//   req_ch   in   valid/ready             command, time_ms
//   rsp_ch   out  valid/ready             kind, rate, start_x/y, end_x/y, slow, last
//   APB      in   psel/penable, pready=1  paddr, pwdata / prdata
//
// One request at a time. A frame that does not close the window stops after
// ST_CHECK; one that closes it goes on through ST_DIV and ST_EMIT. The rate
// divider is serial and yields one of 33 quotient bits per cycle. A plot
// request sets up the x step (P_QUO, P_REM), then one history read per cycle
// unless rsp_ch stalls (64 reads, one memory read port), then a 3-stage drain.
// Reset clears the history at once through per-entry valid bits; no clearing
// pass. A result in the output register does not block the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_meter_with_history_plot (
   input  logic         clock,
   input  logic         reset,
   frm_req_if.sink      req_ch,
   frm_rsp_if.source    rsp_ch,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // register map, byte address 4*index
   localparam logic [2:0] REG_WINDOW = 3'd0;
   localparam logic [2:0] REG_MARK   = 3'd1;
   localparam logic [2:0] REG_LEFT   = 3'd2;
   localparam logic [2:0] REG_TOP    = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic KIND_RATE = 1'b0;
   localparam logic KIND_SEG  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_PLOT  = 5'b10000
   } top_state_type;

   // configuration registers
   logic [frm_pkg::WIN_W-1:0]   window_ff;
   logic [frm_pkg::MARK_W-1:0]  mark_ff;
   logic [frm_pkg::CFG_W-1:0]   left_ff;
   logic [frm_pkg::CFG_W-1:0]   top_ff;
   logic [frm_pkg::CFG_W-1:0]   width_ff;
   logic [frm_pkg::CFG_W-1:0]   height_ff;
   logic                        csr_wr;
   logic [2:0]                  csr_idx;

   // meter state
   top_state_type                state_ff, state_in;
   logic [frm_pkg::TIME_W-1:0]   start_ff;
   logic [frm_pkg::CNT_W-1:0]    count_ff;
   logic [frm_pkg::HIST_AW-1:0]  wp_ff;
   logic [frm_pkg::TIME_W-1:0]   elapsed_ff;
   logic [frm_pkg::TIME_W-1:0]   now_ff;
   logic [frm_pkg::RATE_W-1:0]   rate_ff;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_kind_ff;
   logic [frm_pkg::RATE_W-1:0]   rsp_rate_ff;
   logic [frm_pkg::POS_W-1:0]    rsp_sx_ff, rsp_sy_ff, rsp_ex_ff, rsp_ey_ff;
   logic                         rsp_slow_ff;
   logic                         rsp_last_ff;

   logic                          accept;
   logic                          out_free;
   logic                          close_window;
   logic [frm_pkg::SCALED_W-1:0]  scaled_cnt;
   logic [frm_pkg::DIV_W-1:0]     div_num;
   logic [frm_pkg::DIV_W-1:0]     div_den;
   logic                          div_start;
   logic                          div_done;
   logic [frm_pkg::DIV_W-1:0]     div_quo;
   logic                          emit_rate;
   logic                          plot_start;
   logic                          plot_busy;
   frm_pkg::frm_cfg_type          cfg;
   frm_pkg::frm_rd_type           rd;
   frm_pkg::frm_wr_type           wr;
   frm_pkg::frm_seg_type          seg;
   logic [frm_pkg::RATE_W-1:0]    rd_data;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= frm_pkg::WIN_W'(300);
         mark_ff   <= frm_pkg::MARK_W'(30);
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WINDOW: window_ff <= pwdata[frm_pkg::WIN_W-1:0];
            REG_MARK:   mark_ff   <= pwdata[frm_pkg::MARK_W-1:0];
            REG_LEFT:   left_ff   <= pwdata[frm_pkg::CFG_W-1:0];
            REG_TOP:    top_ff    <= pwdata[frm_pkg::CFG_W-1:0];
            REG_WIDTH:  width_ff  <= pwdata[frm_pkg::CFG_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[frm_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WINDOW: prdata = 32'(window_ff);
         REG_MARK:   prdata = 32'(mark_ff);
         REG_LEFT:   prdata = 32'(left_ff);
         REG_TOP:    prdata = 32'(top_ff);
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      cfg.low_rate_mark = mark_ff;
      cfg.left          = left_ff;
      cfg.top           = top_ff;
      cfg.width         = width_ff;
      cfg.height        = height_ff;
   end

   // ---------------- request sequencing ----------------
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      // window closes once the wrapped elapsed time exceeds window_ms
      close_window = elapsed_ff > frm_pkg::TIME_W'(window_ff);
      scaled_cnt   = frm_pkg::SCALED_W'(count_ff) *
                     frm_pkg::SCALED_W'(frm_pkg::FRAME_SCALE);
      // add elapsed for round-half-up, divide by 2*elapsed
      div_num      = frm_pkg::DIV_W'(scaled_cnt) + frm_pkg::DIV_W'(elapsed_ff);
      div_den      = {elapsed_ff, 1'b0};
      div_start    = (state_ff == ST_CHECK) && close_window;
      emit_rate    = (state_ff == ST_EMIT) && out_free;
      plot_start   = accept && (req_ch.command != CMD_FRAME);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.command == CMD_FRAME) ? ST_CHECK : ST_PLOT;
            end
         end
         ST_CHECK: state_in = close_window ? ST_DIV : ST_IDLE;
         ST_DIV:   if (div_done) state_in = ST_EMIT;
         ST_EMIT:  if (out_free) state_in = ST_IDLE;
         ST_PLOT:  if (!plot_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= '0;
         count_ff <= '0;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req_ch.command == CMD_FRAME && count_ff != '1) begin
            count_ff <= count_ff + 1'b1;
         end
         if (emit_rate) begin
            count_ff <= '0;
            start_ff <= now_ff;
            wp_ff    <= (wp_ff == frm_pkg::HIST_AW'(frm_pkg::STEPS)) ? '0 : wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elapsed_ff <= req_ch.time_ms - start_ff;
         now_ff     <= req_ch.time_ms;
      end
      // saturate the quotient to 16 bits
      if (state_ff == ST_DIV && div_done) begin
         rate_ff <= (div_quo[frm_pkg::DIV_W-1:frm_pkg::RATE_W] != '0) ?
                    '1 : div_quo[frm_pkg::RATE_W-1:0];
      end
   end

   frm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ---------------- history memory ----------------
   always_comb begin
      wr.en   = emit_rate;
      wr.addr = wp_ff;
      wr.data = rate_ff;
   end

   frm_hist_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   frm_plot u_plot (
      .clock   (clock),
      .reset   (reset),
      .start   (plot_start),
      .wp      (wp_ff),
      .cfg     (cfg),
      .adv     (out_free),
      .rd      (rd),
      .rd_data (rd_data),
      .seg     (seg),
      .busy    (plot_busy)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_rate || seg.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_rate) begin
         rsp_kind_ff <= KIND_RATE;
         rsp_rate_ff <= rate_ff;
         rsp_sx_ff   <= '0;
         rsp_sy_ff   <= '0;
         rsp_ex_ff   <= '0;
         rsp_ey_ff   <= '0;
         rsp_slow_ff <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else if (out_free && seg.valid) begin
         rsp_kind_ff <= KIND_SEG;
         rsp_rate_ff <= seg.rate;
         rsp_sx_ff   <= seg.start_x;
         rsp_sy_ff   <= seg.start_y;
         rsp_ex_ff   <= seg.end_x;
         rsp_ey_ff   <= seg.end_y;
         rsp_slow_ff <= seg.slow;
         rsp_last_ff <= seg.last;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.kind    = rsp_kind_ff;
   assign rsp_ch.rate    = rsp_rate_ff;
   assign rsp_ch.start_x = rsp_sx_ff;
   assign rsp_ch.start_y = rsp_sy_ff;
   assign rsp_ch.end_x   = rsp_ex_ff;
   assign rsp_ch.end_y   = rsp_ey_ff;
   assign rsp_ch.slow    = rsp_slow_ff;
   assign rsp_ch.last    = rsp_last_ff;

endmodule

`default_nettype wire
